FILE: sv/shuffling_card_stack_top_defines.svh
// Assertion macros for the shuffling card stack.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef SHUFFLING_CARD_STACK_TOP_DEFINES_SVH
`define SHUFFLING_CARD_STACK_TOP_DEFINES_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scs_pkg.sv
// Shared types, constants and the LFSR step for the shuffling card stack.
// No dependencies.
package scs_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KIND_W   = 3;
  localparam int HELD_W   = 7;
  localparam int LFSR_W   = 32;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_SHUFFLE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [KIND_W-1:0] card_kind;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind_out;
    logic [1:0]        status;
    logic [HELD_W-1:0] entries_held;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              re_a;
    logic [ADDR_W-1:0] addr_a;
    logic              re_b;
    logic [ADDR_W-1:0] addr_b;
  } ram_rd_t;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

FILE: sv/shuffling_card_stack_top.sv
// Shuffling card stack: a bounded stack of card kinds with an in-place shuffle.
// Depends on scs_pkg, scs_card_ram, scs_mod_unit and the defines header.
//
// Usage:
//  - An item (opcode, card_kind) is taken at a clock edge with start high and
//    busy low. Each item yields one result on result, marked by a one-cycle
//    result_valid pulse; the receiver cannot stall and must take it then.
//  - Push, clear, unknown opcodes and every full or empty case: result in the
//    cycle after acceptance, busy stays low, so one item per cycle.
//  - Pop and peek: one card store read; the result goes through the read data
//    register and then the result register, with busy high for one cycle.
//  - Shuffle of n >= 2 entries: n-1 swap steps, each an LFSR advance, a
//    bit-serial modulo, a dual-port read and two writes; busy is high
//    throughout. Fewer than two entries move nothing, and busy stays low.
//  - seed_we/seed_wdata write the seed register at any edge; it takes effect
//    on the next clear (zero loads as 1).
//  - Synchronous reset: empty stack, seed and LFSR at 1, no pending result.
//    The card store is not cleared; only written slots are ever read.
`include "shuffling_card_stack_top_defines.svh"

module shuffling_card_stack_top
  import scs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_item_t          item,
  output logic              busy,
  output logic              result_valid,
  output out_item_t         result,
  input  logic              seed_we,
  input  logic [LFSR_W-1:0] seed_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_SH_ADV = 3'd2;
  localparam logic [2:0] S_SH_MOD = 3'd3;
  localparam logic [2:0] S_SH_RD  = 3'd4;
  localparam logic [2:0] S_SH_WR  = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic [LFSR_W-1:0] seed;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] pos_next;
  logic [ADDR_W-1:0] swap_idx;
  logic [ADDR_W-1:0] swap_idx_next;
  logic              res_vld_next;
  out_item_t         res_next;

  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  logic [KIND_W-1:0] rd_data_a;
  logic [KIND_W-1:0] rd_data_b;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  logic              accept;
  logic [LFSR_W-1:0] lfsr_adv;
  logic [ADDR_W-1:0] top_addr;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign lfsr_adv = lfsr_step(lfsr);
  assign top_addr = ADDR_W'(fill - CNT_W'(1));

  scs_card_ram u_ram (
    .clk       (clk),
    .wr        (ram_wr),
    .rd        (ram_rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  scs_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    lfsr_next     = lfsr;
    pos_next      = pos;
    swap_idx_next = swap_idx;
    res_vld_next  = 1'b0;
    res_next      = '{kind_out: '0, status: ST_OK, entries_held: HELD_W'(fill)};
    ram_wr        = '{we: 1'b0, addr: top_addr, data: item.card_kind};
    ram_rd        = '{re_a: 1'b0, addr_a: top_addr, re_b: 1'b0, addr_b: swap_idx};
    mod_req       = '{start: 1'b0, dividend: lfsr_adv,
                      divisor: CNT_W'(pos) + CNT_W'(1)};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_vld_next = 1'b1;
          unique case (item.opcode) inside
            OP_PUSH: begin
              if (fill == CNT_W'(DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                ram_wr.we             = 1'b1;
                ram_wr.addr           = ADDR_W'(fill);
                fill_next             = fill + CNT_W'(1);
                res_next.entries_held = HELD_W'(fill + CNT_W'(1));
              end
            end
            OP_POP, OP_PEEK: begin
              if (fill == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                // result comes from the registered read next cycle
                res_vld_next = 1'b0;
                ram_rd.re_a  = 1'b1;
                state_next   = S_RD;
                if (item.opcode == OP_POP) begin
                  fill_next = fill - CNT_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              fill_next             = '0;
              lfsr_next             = (seed != '0) ? seed : LFSR_W'(1);
              res_next.entries_held = '0;
            end
            OP_SHUFFLE: begin
              if (fill >= CNT_W'(2)) begin
                res_vld_next = 1'b0;
                pos_next     = top_addr;
                state_next   = S_SH_ADV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        res_vld_next      = 1'b1;
        res_next.kind_out = rd_data_a;
        state_next        = S_IDLE;
      end
      S_SH_ADV: begin
        lfsr_next     = lfsr_adv;
        mod_req.start = 1'b1;
        state_next    = S_SH_MOD;
      end
      S_SH_MOD: begin
        if (mod_rsp.done) begin
          swap_idx_next = mod_rsp.rem;
          ram_rd.re_a   = 1'b1;
          ram_rd.addr_a = pos;
          ram_rd.re_b   = 1'b1;
          ram_rd.addr_b = mod_rsp.rem;
          state_next    = S_SH_RD;
        end
      end
      S_SH_RD: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = pos;
        ram_wr.data = rd_data_b;
        state_next  = S_SH_WR;
      end
      S_SH_WR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = swap_idx;
        ram_wr.data = rd_data_a;
        if (pos == ADDR_W'(1)) begin
          res_vld_next = 1'b1;
          state_next   = S_IDLE;
        end else begin
          pos_next   = pos - ADDR_W'(1);
          state_next = S_SH_ADV;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      lfsr         <= LFSR_W'(1);
      seed         <= LFSR_W'(1);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      lfsr         <= lfsr_next;
      result_valid <= res_vld_next;
      if (seed_we) begin
        seed <= seed_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    swap_idx <= swap_idx_next;
    if (res_vld_next) begin
      result <= res_next;
    end
  end

  `SCS_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CNT_W'(DEPTH), "fill count above depth")
  `SCS_ASSERT_NEXT(a_fill_hold, busy, $stable(fill), "fill count moved while busy")
  `SCS_ASSERT_NEXT(a_accept_ack, accept, result_valid || busy, "accepted item left no trace")
  `SCS_ASSERT_NOW(a_mod_done_state, mod_rsp.done, state == S_SH_MOD,
                  "modulo result outside the wait state")

endmodule

FILE: sv/scs_card_ram.sv
// Card store: one write port, two registered read ports.
// Depends on scs_pkg.
module scs_card_ram
  import scs_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [KIND_W-1:0] rd_data_a,
  output logic [KIND_W-1:0] rd_data_b
);

  logic [KIND_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    // read data holds until the next read on that port
    if (rd.re_a) begin
      rd_data_a <= mem[rd.addr_a];
    end
    if (rd.re_b) begin
      rd_data_b <= mem[rd.addr_b];
    end
  end

endmodule

FILE: sv/scs_mod_unit.sv
// Bit-serial restoring remainder: 32-bit value modulo a small divisor.
// One dividend bit per cycle. Depends on scs_pkg.
module scs_mod_unit
  import scs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(LFSR_W);

  logic              run;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [LFSR_W-1:0] dsr;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  acc_next;

  always_comb begin
    trial = {acc, dsr[LFSR_W-1]};
    if (trial >= {1'b0, dvs}) begin
      acc_next = CNT_W'(trial - {1'b0, dvs});
    end else begin
      acc_next = CNT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(LFSR_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr <= req.dividend;
      dvs <= req.divisor;
      acc <= '0;
    end else if (run) begin
      dsr <= dsr << 1;
      acc <= acc_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = acc[ADDR_W-1:0];

endmodule

FILE: verif/scs_checker.sv
`timescale 1ns / 100ps
// Checker for the shuffling card stack: keeps its own copy of the stack, shuffle LFSR
// and seed register, predicts every result and compares it with what comes out.
// Depends on scs_pkg.
module scs_checker
  import scs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          item,
  input  logic              result_valid,
  input  out_item_t         result,
  input  logic              seed_we,
  input  logic [LFSR_W-1:0] seed_wdata,
  output int                err_count,
  output int                due_count
);

  logic [KIND_W-1:0] cards [DEPTH];
  int                depth_now;
  logic [LFSR_W-1:0] shuffle_lfsr;
  logic [LFSR_W-1:0] seed_reg;
  out_item_t         awaited_results [$];

  function automatic logic [LFSR_W-1:0] galois_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] shifted;
    shifted = v >> 1;
    return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

  // Fisher-Yates from the top slot down; nothing moves below two entries
  function automatic void shuffle_cards();
    logic [LFSR_W-1:0] span;
    logic [LFSR_W-1:0] pick;
    logic [KIND_W-1:0] held;
    for (int i = depth_now - 1; i > 0; i--) begin
      shuffle_lfsr = galois_next(shuffle_lfsr);
      span = LFSR_W'(i + 1);
      pick = shuffle_lfsr % span;
      held = cards[i];
      cards[i] = cards[pick];
      cards[pick] = held;
    end
  endfunction

  function automatic out_item_t stack_result(input in_item_t it);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (it.opcode)
      OP_PUSH: begin
        if (depth_now >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cards[depth_now] = it.card_kind;
          depth_now++;
        end
      end
      OP_POP: begin
        if (depth_now == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth_now--;
          r.kind_out = cards[depth_now];
        end
      end
      OP_PEEK: begin
        if (depth_now == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.kind_out = cards[depth_now - 1];
        end
      end
      OP_CLEAR: begin
        depth_now = 0;
        shuffle_lfsr = (seed_reg == '0) ? LFSR_W'(1) : seed_reg;
      end
      OP_SHUFFLE: begin
        shuffle_cards();
      end
      default: begin
      end
    endcase
    r.entries_held = HELD_W'(depth_now);
    return r;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      depth_now = 0;
      shuffle_lfsr = LFSR_W'(1);
      seed_reg = LFSR_W'(1);
      awaited_results.delete();
    end else begin
      // results come from items taken at earlier edges, so check them first
      if (result_valid) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind_out %0d status %0d entries_held %0d",
                 result.kind_out, result.status, result.entries_held);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("kind_out", want.kind_out, result.kind_out);
          compare_field("status", want.status, result.status);
          compare_field("entries_held", want.entries_held, result.entries_held);
          if ($isunknown(result)) begin
            $error("result has unknown bits: expected %h, got %h", want, result);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(stack_result(item));
      end
      if (seed_we) begin
        seed_reg = seed_wdata;
      end
    end
    due_count = awaited_results.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the shuffling card stack: clock, reset, item and seed stimulus,
// and the verdict. Depends on scs_pkg, shuffling_card_stack_top and scs_checker.
module tb_top;
  import scs_pkg::*;

  localparam int         MAX_CYCLES   = 10_000_000;
  localparam int         MIX_ITEMS    = 50;
  localparam int         BURST_ITEMS  = 70;
  localparam int         PHASES       = 4;
  localparam logic [2:0] OP_UNUSED_LO = OP_SHUFFLE + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              result_valid;
  logic              seed_we;
  logic [LFSR_W-1:0] seed_wdata;
  in_item_t          item;
  out_item_t         result;
  int                err_count;
  int                due_count;
  int                cycle_count;
  bit                gaps_on;
  logic [LFSR_W-1:0] phase_seeds [PHASES];

  shuffling_card_stack_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata)
  );

  scs_checker u_scs_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata),
    .err_count    (err_count),
    .due_count    (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [KIND_W-1:0] rand_kind();
    return KIND_W'($urandom);
  endfunction

  // push_pct sets how the mix leans: high builds the stack up, low drains it
  function automatic logic [2:0] pick_op(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return OP_PUSH;
    if (roll < 75) return OP_POP;
    if (roll < 88) return OP_PEEK;
    if (roll < 94) return OP_SHUFFLE;
    if (roll < 97) return OP_CLEAR;
    return 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [KIND_W-1:0] kind);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 27) begin
      start = 1'b0;
      item = in_item_t'($bits(in_item_t)'($urandom));
      @(negedge clk);
    end
    start = 1'b1;
    item.opcode = op;
    item.card_kind = kind;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (due_count != 0 || busy) @(negedge clk);
  endtask

  // seed only changes with the stack idle
  task automatic write_seed(input logic [LFSR_W-1:0] v);
    wait_quiet();
    seed_we = 1'b1;
    seed_wdata = v;
    @(negedge clk);
    seed_we = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    seed_we = 1'b0;
    seed_wdata = '0;
    gaps_on = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // empty stack cases and unknown opcodes
    send_op(OP_POP, 3'd5);
    send_op(OP_PEEK, 3'd7);
    send_op(OP_SHUFFLE, 3'd0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      send_op(3'(op), 3'd7);
    end
    // single-entry shuffle, then a real one on the reset LFSR
    send_op(OP_PUSH, 3'd7);
    send_op(OP_SHUFFLE, 3'd0);
    send_op(OP_PEEK, 3'd0);
    send_op(OP_PUSH, 3'd0);
    send_op(OP_PUSH, 3'd5);
    send_op(OP_PUSH, 3'd3);
    send_op(OP_SHUFFLE, 3'd7);
    send_op(OP_PEEK, 3'd2);
    repeat (4) send_op(OP_POP, 3'd1);
    // zero seed must load as one
    write_seed('0);
    send_op(OP_CLEAR, 3'd4);
    send_op(OP_PUSH, 3'd1);
    send_op(OP_PUSH, 3'd2);
    send_op(OP_PUSH, 3'd6);
    send_op(OP_SHUFFLE, 3'd0);
    send_op(OP_POP, 3'd0);

    phase_seeds[0] = 32'hFFFF_FFFF;
    phase_seeds[1] = 32'h8000_0000;
    phase_seeds[2] = 32'h0000_0001;
    phase_seeds[3] = LFSR_W'($urandom);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_seed(phase_seeds[ph]);
      gaps_on = (ph != 2);
      send_op(OP_CLEAR, rand_kind());
      for (int n = 0; n < MIX_ITEMS; n++) begin
        send_op(pick_op(30), rand_kind());
      end
      // fill past the top so pushes see a full stack
      for (int n = 0; n < BURST_ITEMS; n++) begin
        send_op(OP_PUSH, rand_kind());
      end
      for (int n = 0; n < MIX_ITEMS; n++) begin
        send_op(pick_op(55), rand_kind());
      end
      for (int n = 0; n < BURST_ITEMS; n++) begin
        send_op(OP_POP, rand_kind());
      end
    end

    wait_quiet();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
